### hdl/charlieplex_matrix_scan_driver_defines.svh
// assertion macros shared by the scan driver rtl
`ifndef CHARLIEPLEX_MATRIX_SCAN_DRIVER_DEFINES_SVH
`define CHARLIEPLEX_MATRIX_SCAN_DRIVER_DEFINES_SVH

// same-cycle implication, held off during reset
`define CMSD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define CMSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/cmsd_pkg.sv
// shared types, constants and lookup functions of the matrix scan driver
`timescale 1ns / 1ps
`default_nettype none

package cmsd_pkg;

    localparam int PIN_COUNT    = 16;
    localparam int PIXEL_COUNT  = 240;
    localparam int COLS_PER_ROW = PIN_COUNT - 1;

    localparam int ROW_W   = 4;
    localparam int PIN_W   = 16;
    localparam int PIXEL_W = 8;
    localparam int FUNC_W  = 2;
    localparam int TIME_W  = 16;
    localparam int SHIFT_W = 4;
    localparam int CNT_W   = 5;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;

    // v / 15 for v < 240 as (v * 137) >> 11
    localparam logic [PIXEL_W-1:0] ROW_RECIP       = 8'd137;
    localparam int                 ROW_RECIP_SHIFT = 11;

    localparam logic [TIME_W-1:0]  RESET_PERIOD = 16'd1000;
    localparam logic [TIME_W-1:0]  RESET_COMP   = 16'd0;
    localparam logic [SHIFT_W-1:0] RESET_DIM    = 4'd2;
    localparam logic [TIME_W-1:0]  RESET_FIXED  = 16'd0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SET_ROW = 2'd0,
        FUNC_SET     = 2'd1,
        FUNC_COMMIT  = 2'd2,
        FUNC_TICK    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        REG_PERIOD = 2'd0,
        REG_COMP   = 2'd1,
        REG_DIM    = 2'd2,
        REG_FIXED  = 2'd3
    } t_reg;

    typedef struct packed {
        logic [ROW_W-1:0]  scan_row;
        logic [PIN_W-1:0]  drive_enable;
        logic [PIN_W-1:0]  drive_high;
        logic [TIME_W-1:0] on_compare;
        logic              bad_pixel;
    } t_res;

    // logical to physical led index
    localparam logic [PIXEL_W-1:0] PIXEL_MAP [PIXEL_COUNT] = '{
        8'd101, 8'd26,  8'd181, 8'd211, 8'd28,  8'd43,  8'd212, 8'd167,
        8'd40,  8'd160, 8'd175, 8'd9,   8'd150, 8'd60,  8'd3,   8'd68,
        8'd20,  8'd91,  8'd222, 8'd193, 8'd31,  8'd16,  8'd178, 8'd221,
        8'd152, 8'd39,  8'd10,  8'd165, 8'd69,  8'd154, 8'd135, 8'd8,
        8'd46,  8'd216, 8'd103, 8'd41,  8'd182, 8'd166, 8'd25,  8'd163,
        8'd220, 8'd1,   8'd30,  8'd70,  8'd169, 8'd144, 8'd159, 8'd12,
        8'd213, 8'd58,  8'd35,  8'd92,  8'd176, 8'd191, 8'd151, 8'd24,
        8'd13,  8'd210, 8'd62,  8'd33,  8'd145, 8'd174, 8'd205, 8'd162,
        8'd88,  8'd32,  8'd47,  8'd171, 8'd100, 8'd161, 8'd190, 8'd0,
        8'd15,  8'd73,  8'd214, 8'd137, 8'd38,  8'd206, 8'd177, 8'd158,
        8'd34,  8'd77,  8'd168, 8'd55,  8'd156, 8'd99,  8'd11,  8'd180,
        8'd61,  8'd18,  8'd148, 8'd219, 8'd197, 8'd42,  8'd130, 8'd173,
        8'd107, 8'd170, 8'd85,  8'd153, 8'd54,  8'd5,   8'd90,  8'd71,
        8'd184, 8'd136, 8'd23,  8'd208, 8'd223, 8'd122, 8'd37,  8'd179,
        8'd172, 8'd115, 8'd155, 8'd84,  8'd2,   8'd45,  8'd65,  8'd94,
        8'd146, 8'd189, 8'd196, 8'd27,  8'd133, 8'd218, 8'd227, 8'd44,
        8'd236, 8'd157, 8'd114, 8'd4,   8'd75,  8'd63,  8'd48,  8'd141,
        8'd98,  8'd207, 8'd192, 8'd121, 8'd22,  8'd239, 8'd224, 8'd36,
        8'd164, 8'd235, 8'd6,   8'd105, 8'd64,  8'd79,  8'd138, 8'd53,
        8'd201, 8'd102, 8'd131, 8'd188, 8'd226, 8'd29,  8'd118, 8'd217,
        8'd129, 8'd14,  8'd225, 8'd66,  8'd109, 8'd140, 8'd83,  8'd198,
        8'd57,  8'd126, 8'd97,  8'd237, 8'd194, 8'd106, 8'd21,  8'd215,
        8'd7,   8'd120, 8'd74,  8'd229, 8'd142, 8'd113, 8'd200, 8'd87,
        8'd123, 8'd52,  8'd231, 8'd104, 8'd116, 8'd187, 8'd76,  8'd19,
        8'd195, 8'd67,  8'd124, 8'd149, 8'd234, 8'd202, 8'd117, 8'd125,
        8'd82,  8'd228, 8'd59,  8'd111, 8'd96,  8'd86,  8'd185, 8'd17,
        8'd72,  8'd199, 8'd143, 8'd128, 8'd209, 8'd238, 8'd127, 8'd112,
        8'd230, 8'd89,  8'd108, 8'd51,  8'd80,  8'd95,  8'd56,  8'd183,
        8'd139, 8'd147, 8'd204, 8'd203, 8'd132, 8'd134, 8'd233, 8'd232,
        8'd119, 8'd110, 8'd81,  8'd78,  8'd49,  8'd50,  8'd93,  8'd186
    };

    // table read, out-of-range indices give zero
    function automatic logic [PIXEL_W-1:0] pixel_lookup(input logic [PIXEL_W-1:0] idx);
        logic [PIXEL_W-1:0] v;
        v = '0;
        if (idx < PIXEL_COUNT) begin
            v = PIXEL_MAP[idx];
        end
        return v;
    endfunction

    // one-hot pin mask
    function automatic logic [PIN_W-1:0] pin_bit(input logic [ROW_W-1:0] pin);
        return PIN_W'(1) << pin;
    endfunction

    // number of set bits in a row mask
    function automatic logic [CNT_W-1:0] popcount(input logic [PIN_W-1:0] m);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int b = 0; b < PIN_W; b++) begin
            c = c + CNT_W'(m[b]);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hdl/cmsd_cmd_if.sv
// command channel: function code, pixel index and on/off flag
`timescale 1ns / 1ps
`default_nettype none

interface cmsd_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [cmsd_pkg::FUNC_W-1:0]   func;
    logic [cmsd_pkg::PIXEL_W-1:0]  pixel;
    logic                          lit;

    modport source (output valid, output func, output pixel, output lit, input ready);
    modport sink   (input valid, input func, input pixel, input lit, output ready);
endinterface

`default_nettype wire

### hdl/cmsd_res_if.sv
// result channel: row drive masks, on-compare and bad pixel flag
`timescale 1ns / 1ps
`default_nettype none

interface cmsd_res_if;
    logic                         valid;
    logic                         ready;
    logic [cmsd_pkg::ROW_W-1:0]   scan_row;
    logic [cmsd_pkg::PIN_W-1:0]   drive_enable;
    logic [cmsd_pkg::PIN_W-1:0]   drive_high;
    logic [cmsd_pkg::TIME_W-1:0]  on_compare;
    logic                         bad_pixel;

    modport source (output valid, output scan_row, output drive_enable, output drive_high,
                    output on_compare, output bad_pixel, input ready);
    modport sink   (input valid, input scan_row, input drive_enable, input drive_high,
                    input on_compare, input bad_pixel, output ready);
endinterface

`default_nettype wire

### hdl/cmsd_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module cmsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [WIDTH-1:0]           i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [WIDTH-1:0]           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hdl/charlieplex_matrix_scan_driver.sv
// top level of the 16-pin matrix scan driver: command sequencer, row memories, apb registers
//
// channel  dir  handshake        payload
// i_cmd    in   valid / ready    func, pixel, lit
// o_res    out  valid / ready    scan_row, drive_enable, drive_high, on_compare, bad_pixel
// apb      in   psel / penable   paddr[3:2] register, pwdata in, prdata out
//
// one command at a time; states from transfer to result register:
//   tick TICK, DONE; bad pixel MAP, DONE; pixel set MAP, RMW, DONE;
//   pixel set with row update MAP, RMW, CALC, DIM, DONE;
//   commit ALL, CALC, DIM per row then DONE in auto mode, DONE alone in fixed mode.
// reset needs no clearing pass: per-row valid bits stand in for the reset contents.
// command ready stays low while reset is held.
// a new command is taken while a result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "charlieplex_matrix_scan_driver_defines.svh"

module charlieplex_matrix_scan_driver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cmsd_cmd_if.sink                      i_cmd,
    cmsd_res_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cmsd_pkg::ADDR_W-1:0]   paddr,
    input  logic [cmsd_pkg::DATA_W-1:0]   pwdata,
    output logic [cmsd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    import cmsd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_MAP,
        S_RMW,
        S_ALL,
        S_CALC,
        S_DIM,
        S_DONE
    } t_state;

    // configuration registers
    logic [TIME_W-1:0]  r_period;
    logic [TIME_W-1:0]  r_comp;
    logic [SHIFT_W-1:0] r_dim;
    logic [TIME_W-1:0]  r_fixed;
    logic [TIME_W-1:0]  r_bulk;

    // sequencer state
    t_state             r_state;
    t_func              r_func;
    logic [PIXEL_W-1:0] r_pixel;
    logic               r_lit;
    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_ptr;
    logic [PIN_W-1:0]   r_new;
    logic [TIME_W-1:0]  r_p;
    logic [PIN_COUNT-1:0] r_mask_vld;
    logic [PIN_COUNT-1:0] r_time_vld;
    t_res               r_pend;
    t_res               r_res;
    logic               r_res_valid;

    // apb decode
    logic               w_cfg_wr;
    t_reg               w_cfg_idx;
    logic [TIME_W-1:0]  w_cfg_val;
    logic               w_reload;

    // command channel
    logic               w_accept;
    t_func              w_func;

    // memory ports
    logic               w_mrd_en;
    logic [ROW_W-1:0]   w_mrd_addr;
    logic [PIN_W-1:0]   w_mrd_data;
    logic               w_mwr_en;
    logic               w_trd_en;
    logic [TIME_W-1:0]  w_trd_data;
    logic               w_twr_en;

    // datapath
    logic [PIXEL_W-1:0] w_v;
    logic [2*PIXEL_W-1:0] w_prod;
    logic [ROW_W-1:0]   w_map_row;
    logic [PIXEL_W-1:0] w_rem;
    logic [ROW_W-1:0]   w_map_col;
    logic               w_bad;
    logic [PIN_W-1:0]   w_mask_cur;
    logic [PIN_W-1:0]   w_tick_mask;
    logic [TIME_W-1:0]  w_tick_time;
    logic [TIME_W-1:0]  w_tick_cmp;
    logic [PIN_W-1:0]   n_mask;
    logic [TIME_W-1:0]  n_cnt;
    logic [TIME_W-1:0]  n_p;
    logic [TIME_W-1:0]  n_on;

    // apb: always ready, write on the access cycle
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = t_reg'(paddr[ADDR_W-1:2]);
    assign w_cfg_val = pwdata[TIME_W-1:0];
    assign w_reload  = w_cfg_wr && ((w_cfg_idx == REG_COMP) ||
                                    ((w_cfg_idx == REG_FIXED) && (w_cfg_val != '0)));

    // register writes; a compensation or nonzero fixed write reloads every row on-time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= RESET_PERIOD;
            r_comp   <= RESET_COMP;
            r_dim    <= RESET_DIM;
            r_fixed  <= RESET_FIXED;
            r_bulk   <= RESET_PERIOD - RESET_COMP;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_PERIOD: begin
                    r_period <= w_cfg_val;
                end
                REG_COMP: begin
                    r_comp <= w_cfg_val;
                    r_bulk <= r_period - w_cfg_val;
                end
                REG_DIM: begin
                    r_dim <= pwdata[SHIFT_W-1:0];
                end
                REG_FIXED: begin
                    r_fixed <= w_cfg_val;
                    if (w_cfg_val != '0) begin
                        r_bulk <= r_period - w_cfg_val;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // register read-back
    always_comb begin
        case (w_cfg_idx)
            REG_PERIOD: prdata = DATA_W'(r_period);
            REG_COMP:   prdata = DATA_W'(r_comp);
            REG_DIM:    prdata = DATA_W'(r_dim);
            REG_FIXED:  prdata = DATA_W'(r_fixed);
            default:    prdata = '0;
        endcase
    end

    // command transfer
    assign i_cmd.ready = i_rst_n && (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_func      = t_func'(i_cmd.func);

    // pixel to row and column: divide by 15 via reciprocal, skip the row's own pin
    assign w_v       = pixel_lookup(r_pixel);
    assign w_prod    = (2*PIXEL_W)'(w_v) * (2*PIXEL_W)'(ROW_RECIP);
    assign w_map_row = w_prod[ROW_RECIP_SHIFT +: ROW_W];
    assign w_rem     = w_v - PIXEL_W'(w_map_row) * PIXEL_W'(COLS_PER_ROW);
    assign w_map_col = (w_rem[ROW_W-1:0] >= w_map_row) ? (w_rem[ROW_W-1:0] + ROW_W'(1))
                                                       : w_rem[ROW_W-1:0];
    assign w_bad     = (r_pixel >= PIXEL_W'(PIXEL_COUNT));

    // memory data with unwritten rows standing at their reset contents
    assign w_mask_cur  = r_mask_vld[r_row] ? w_mrd_data : pin_bit(r_row);
    assign w_tick_mask = r_mask_vld[r_ptr] ? w_mrd_data : pin_bit(r_ptr);
    assign w_tick_time = r_time_vld[r_ptr] ? w_trd_data : r_bulk;
    assign w_tick_cmp  = (r_fixed != '0) ? (r_period - r_fixed) : w_tick_time;

    // mask update and on-time arithmetic
    assign n_mask = r_lit ? (w_mask_cur | pin_bit(r_col)) : (w_mask_cur & ~pin_bit(r_col));
    assign n_cnt  = TIME_W'(popcount(r_new)) - TIME_W'(1);
    assign n_p    = r_period - n_cnt;
    assign n_on   = r_p - (r_p >> r_dim);

    // memory read address select
    always_comb begin
        w_mrd_en   = 1'b0;
        w_mrd_addr = r_ptr;
        w_trd_en   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (w_func == FUNC_TICK)) begin
                    w_mrd_en = 1'b1;
                    w_trd_en = 1'b1;
                end else if (w_accept && (w_func == FUNC_COMMIT) && (r_fixed == '0)) begin
                    w_mrd_en   = 1'b1;
                    w_mrd_addr = '0;
                end
            end
            S_MAP: begin
                w_mrd_en   = !w_bad;
                w_mrd_addr = w_map_row;
            end
            S_DIM: begin
                w_mrd_en   = (r_func == FUNC_COMMIT) && (r_row != '1);
                w_mrd_addr = r_row + ROW_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign w_mwr_en = (r_state == S_RMW);
    assign w_twr_en = (r_state == S_DIM);

    // row enable masks
    cmsd_ram #(
        .WIDTH (PIN_W),
        .DEPTH (PIN_COUNT)
    ) u_mask_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_mwr_en),
        .i_wr_addr (r_row),
        .i_wr_data (n_mask),
        .i_rd_en   (w_mrd_en),
        .i_rd_addr (w_mrd_addr),
        .o_rd_data (w_mrd_data)
    );

    // row on-times
    cmsd_ram #(
        .WIDTH (TIME_W),
        .DEPTH (PIN_COUNT)
    ) u_time_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_twr_en),
        .i_wr_addr (r_row),
        .i_wr_data (n_on),
        .i_rd_en   (w_trd_en),
        .i_rd_addr (r_ptr),
        .o_rd_data (w_trd_data)
    );

    // sequencer: each memory access finishes before the next touches the same row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_mask_vld  <= '0;
            r_time_vld  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
            if (w_reload) begin
                r_time_vld <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func  <= w_func;
                        r_pixel <= i_cmd.pixel;
                        r_lit   <= i_cmd.lit;
                        r_pend  <= '0;
                        r_row   <= '0;
                        case (w_func)
                            FUNC_TICK:   r_state <= S_TICK;
                            FUNC_COMMIT: r_state <= (r_fixed != '0) ? S_DONE : S_ALL;
                            default:     r_state <= S_MAP;
                        endcase
                    end
                end
                S_TICK: begin
                    r_pend.scan_row     <= r_ptr;
                    r_pend.drive_enable <= w_tick_mask;
                    r_pend.drive_high   <= pin_bit(r_ptr);
                    r_pend.on_compare   <= w_tick_cmp;
                    r_ptr               <= r_ptr + ROW_W'(1);
                    r_state             <= S_DONE;
                end
                S_MAP: begin
                    if (w_bad) begin
                        r_pend.bad_pixel <= 1'b1;
                        r_state          <= S_DONE;
                    end else begin
                        r_row   <= w_map_row;
                        r_col   <= w_map_col;
                        r_state <= S_RMW;
                    end
                end
                S_RMW: begin
                    r_mask_vld[r_row] <= 1'b1;
                    r_new             <= n_mask;
                    r_state <= ((r_func == FUNC_SET_ROW) && (r_fixed == '0)) ? S_CALC : S_DONE;
                end
                S_ALL: begin
                    r_new   <= w_mask_cur;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_p     <= n_p;
                    r_state <= S_DIM;
                end
                S_DIM: begin
                    r_time_vld[r_row] <= 1'b1;
                    if ((r_func == FUNC_COMMIT) && (r_row != '1)) begin
                        r_row   <= r_row + ROW_W'(1);
                        r_state <= S_ALL;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_res_valid || o_res.ready) begin
                        r_res       <= r_pend;
                        r_res_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result channel
    assign o_res.valid        = r_res_valid;
    assign o_res.scan_row     = r_res.scan_row;
    assign o_res.drive_enable = r_res.drive_enable;
    assign o_res.drive_high   = r_res.drive_high;
    assign o_res.on_compare   = r_res.on_compare;
    assign o_res.bad_pixel    = r_res.bad_pixel;

    // checks
    `CMSD_ASSERT_IMPL(a_row_pin_enabled, i_clk, i_rst_n,
        r_res_valid && (r_res.drive_high != '0),
        (r_res.drive_enable & r_res.drive_high) == r_res.drive_high,
        "driven row pin missing from enable mask")
    `CMSD_ASSERT_IMPL(a_high_onehot, i_clk, i_rst_n, r_res_valid,
        $onehot0(r_res.drive_high) && !(r_res.bad_pixel && (r_res.drive_high != '0)),
        "bad drive_high mask")
    `CMSD_ASSERT_IMPL(a_col_not_row, i_clk, i_rst_n, r_state == S_RMW, r_col != r_row,
        "pixel column maps onto its own row pin")
    `CMSD_ASSERT_NEXT(a_tick_advance, i_clk, i_rst_n, r_state == S_TICK,
        r_ptr == ($past(r_ptr) + ROW_W'(1)),
        "scan pointer did not advance on tick")

endmodule

`default_nettype wire
